@@ rtl/go_to_goal_heading_controller_core_assert.svh @@
// assertion macros for the go-to-goal controller
`ifndef GO_TO_GOAL_HEADING_CONTROLLER_CORE_ASSERT_SVH
`define GO_TO_GOAL_HEADING_CONTROLLER_CORE_ASSERT_SVH
`ifndef SYNTH
`define GTG_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define GTG_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define GTG_ASSERT_IMPL(label, clk, rst_n, a, c)
`define GTG_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ rtl/gtg_pkg.sv @@
`default_nettype none
package gtg_pkg;
    localparam int CordicStepsDefault = 16;
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_GOAL   = 2'd1;
    localparam logic [1:0] OP_RESUME = 2'd2;
    localparam logic [2:0] REG_LIN_GAIN = 3'd0;
    localparam logic [2:0] REG_ANG_GAIN = 3'd1;
    localparam logic [2:0] REG_MAX_LIN  = 3'd2;
    localparam logic [2:0] REG_MAX_ANG  = 3'd3;
    localparam logic [2:0] REG_RADIUS   = 3'd4;
    localparam logic [2:0] REG_GATE     = 3'd5;
    localparam logic [2:0] REG_LIMIT    = 3'd6;
    localparam logic [63:0] INV_GAIN_Q30 = 64'd652032874;
    localparam logic [31:0] PI_Q29 = 32'd1686629713;

    typedef struct packed {
        logic load;     // load difference vector, start cordic
        logic step;     // one cordic iteration
        logic finish;   // compute distance
        logic mul_a;    // gain products
        logic mul_b;
        logic result;   // form outputs
    } t_cmd;

    typedef struct packed {
        logic cordic_done;
    } t_status;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051E;
            5'd2: v = 32'h09FB385B;  5'd3: v = 32'h051111D4;
            5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
            5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;
            5'd8: v = 32'h0028BE53;  5'd9: v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

@@ rtl/gtg_datapath.sv @@
`default_nettype none
module gtg_datapath #(
    parameter int CORDIC_STEPS = gtg_pkg::CordicStepsDefault
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gtg_pkg::t_cmd     i_cmd,
    output gtg_pkg::t_status       o_status,
    input  wire logic [31:0]       i_goal_x,
    input  wire logic [31:0]       i_goal_y,
    input  wire logic [31:0]       i_coord_x,
    input  wire logic [31:0]       i_coord_y,
    input  wire logic [15:0]       i_heading,
    input  wire logic [15:0]       i_linear_gain,
    input  wire logic [15:0]       i_angular_gain,
    input  wire logic [30:0]       i_max_linear_speed,
    input  wire logic [30:0]       i_max_angular_speed,
    input  wire logic [30:0]       i_arrival_radius,
    input  wire logic [14:0]       i_heading_gate,
    output logic                   o_arrived,
    output logic [30:0]            o_linear_cmd,
    output logic [31:0]            o_angular_cmd
);
    import gtg_pkg::*;
    localparam int XW = 36;
    localparam int IW = $clog2(CORDIC_STEPS + 1);

    logic signed [XW-1:0] r_x, r_y, n_x, n_y;
    logic [31:0] r_z, n_z;
    logic [IW-1:0] r_i;
    logic [63:0] r_dist;
    logic [15:0] r_err_abs;
    logic r_err_neg;
    logic [48:0] r_lin_prod;
    logic [31:0] r_ang_part;
    logic [63:0] r_ang_prod;

    logic signed [32:0] dx, dy;
    logic signed [XW-1:0] xs, ys;
    logic [4:0] sh;
    logic [15:0] bearing, diff;
    logic [63:0] mag;

    assign dx = 33'(signed'(i_goal_x)) - 33'(signed'(i_coord_x));
    assign dy = 33'(signed'(i_goal_y)) - 33'(signed'(i_coord_y));
    assign sh = 5'(r_i);
    assign xs = r_x >>> sh;
    assign ys = r_y >>> sh;
    assign bearing = 16'((r_z + 32'h8000) >> 16);
    assign diff = bearing - i_heading;
    assign mag = (r_x > 0) ? 64'(r_x) : 64'd0;

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (i_cmd.load) begin
            if (dx < 0) begin
                n_x = -XW'(dx);
                n_y = -XW'(dy);
                n_z = 32'h80000000;
            end else begin
                n_x = XW'(dx);
                n_y = XW'(dy);
                n_z = 32'd0;
            end
        end else if (i_cmd.step) begin
            if (r_y < 0) begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - atan_lut(sh);
            end else begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + atan_lut(sh);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        if (!i_rst_n || i_cmd.load) begin
            r_i <= '0;
        end else if (i_cmd.step) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.finish) begin
            r_dist <= (mag * INV_GAIN_Q30 + 64'h20000000) >> 30;
            r_err_neg <= diff[15];
            r_err_abs <= diff[15] ? 16'(-diff) : diff;
        end
        if (i_cmd.mul_a) begin
            r_lin_prod <= 49'(i_linear_gain) * 49'(r_dist[32:0]);
            r_ang_part <= 32'(i_angular_gain) * 32'(r_err_abs);
        end
        if (i_cmd.mul_b) begin
            r_ang_prod <= 64'(r_ang_part) * 64'(PI_Q29);
        end
    end

    logic [63:0] lin, amag;
    logic [31:0] amag_c;
    always_comb begin
        lin = 64'(r_lin_prod) >> 8;
        if (lin > 64'(i_max_linear_speed)) begin
            lin = 64'(i_max_linear_speed);
        end
        if (!(17'(r_err_abs) < 17'(i_heading_gate))) begin
            lin = '0;
        end
        amag = r_ang_prod >> 36;
        if (amag > 64'(i_max_angular_speed)) begin
            amag = 64'(i_max_angular_speed);
        end
        amag_c = amag[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            o_linear_cmd <= lin[30:0];
            o_angular_cmd <= r_err_neg ? -amag_c : amag_c;
        end
    end

    assign o_arrived = r_dist <= 64'(i_arrival_radius);
    assign o_status.cordic_done = (32'(r_i) >= 32'(CORDIC_STEPS)) || (32'(r_i) >= 32);
endmodule
`default_nettype wire

@@ rtl/gtg_controller.sv @@
`default_nettype none
module gtg_controller (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire gtg_pkg::t_status  i_status,
    input  wire logic              i_arrived,
    output gtg_pkg::t_cmd          o_cmd,
    output logic                   o_busy,
    output logic                   o_decide
);
    import gtg_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0, S_CORD = 3'd1, S_FIN = 3'd2,
        S_DEC = 3'd3, S_MB = 3'd4, S_RES = 3'd5;
    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_decide = 1'b0;
        case (r_state)
            S_IDLE: if (i_start) begin
                o_cmd.load = 1'b1;
                n_state = S_CORD;
            end
            S_CORD: if (i_status.cordic_done) begin
                n_state = S_FIN;
            end else begin
                o_cmd.step = 1'b1;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.mul_a = 1'b1;
                o_decide = i_arrived;
                n_state = i_arrived ? S_IDLE : S_MB;
            end
            S_MB: begin
                o_cmd.mul_b = 1'b1;
                n_state = S_RES;
            end
            S_RES: begin
                o_cmd.result = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
    assign o_busy = r_state != S_IDLE;
endmodule
`default_nettype wire

@@ rtl/go_to_goal_heading_controller_core.sv @@
`default_nettype none
// go-to-goal steering controller. an armed tick runs a CORDIC_STEPS-iteration
// vectoring cordic, one iteration per cycle, then a done check, scaling, the
// two gain multiplies and the result stage, and the word goes through the output
// register; a stop at the goal is instead written to the output register from
// the first multiply step. a reroute-limit stop is valid the cycle after its
// tick; set-goal, resume and idle ticks give no word. one result word per
// armed tick, held in an output register; no new word is accepted until it has
// been taken.
module go_to_goal_heading_controller_core #(
    parameter int CORDIC_STEPS = gtg_pkg::CordicStepsDefault
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [79:0]  s_axis_tdata,  // coord_x, coord_y, heading
    input  wire logic [1:0]   s_axis_tuser,  // op
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [63:0]       m_axis_tdata,  // linear_cmd, angular_cmd
    output logic              m_axis_tuser,  // reached flag
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import gtg_pkg::*;
    logic [15:0] r_lin_gain, r_ang_gain;
    logic [30:0] r_max_lin, r_max_ang, r_radius;
    logic [14:0] r_gate;
    logic [3:0] r_limit, r_count;
    logic [31:0] r_goal_x, r_goal_y, r_cx, r_cy;
    logic [15:0] r_hd;
    logic r_armed, r_out_valid, r_out_reached, r_from_dp;
    logic [30:0] r_out_lin;
    logic [31:0] r_out_ang;

    t_cmd cmd;
    t_status status;
    logic busy, decide, arrived, start;
    logic [30:0] dp_lin;
    logic [31:0] dp_ang;
    logic in_acc, wr;
    logic [1:0] op;
    logic [2:0] ridx;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];
    assign wr = psel && penable && pwrite;
    always_comb begin
        case (ridx)
            REG_LIN_GAIN: prdata = 32'(r_lin_gain);
            REG_ANG_GAIN: prdata = 32'(r_ang_gain);
            REG_MAX_LIN:  prdata = 32'(r_max_lin);
            REG_MAX_ANG:  prdata = 32'(r_max_ang);
            REG_RADIUS:   prdata = 32'(r_radius);
            REG_GATE:     prdata = 32'(r_gate);
            REG_LIMIT:    prdata = 32'(r_limit);
            default:      prdata = 32'd0;
        endcase
    end

    assign s_axis_tready = !busy && !r_out_valid && !r_from_dp;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign op = s_axis_tuser;
    assign start = in_acc && op == OP_TICK && r_armed && !(r_count > r_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_gain <= 16'd51;
            r_ang_gain <= 16'd128;
            r_max_lin <= 31'd26214;
            r_max_ang <= 31'd32768;
            r_radius <= 31'd49152;
            r_gate <= 15'd3687;
            r_limit <= 4'd10;
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_armed <= 1'b0;
            r_count <= '0;
            r_out_valid <= 1'b0;
            r_from_dp <= 1'b0;
        end else begin
            if (wr) begin
                case (ridx)
                    REG_LIN_GAIN: r_lin_gain <= pwdata[15:0];
                    REG_ANG_GAIN: r_ang_gain <= pwdata[15:0];
                    REG_MAX_LIN:  r_max_lin <= pwdata[30:0];
                    REG_MAX_ANG:  r_max_ang <= pwdata[30:0];
                    REG_RADIUS:   r_radius <= pwdata[30:0];
                    REG_GATE:     r_gate <= pwdata[14:0];
                    REG_LIMIT:    r_limit <= pwdata[3:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_from_dp <= cmd.result;
            if (r_from_dp) begin
                r_out_valid <= 1'b1;
                r_out_reached <= 1'b0;
            end
            if (decide) begin
                r_armed <= 1'b0;
                r_out_valid <= 1'b1;
                r_out_reached <= 1'b1;
                r_out_lin <= '0;
                r_out_ang <= '0;
            end
            if (in_acc) begin
                case (op)
                    OP_GOAL: begin
                        r_goal_x <= s_axis_tdata[31:0];
                        r_goal_y <= s_axis_tdata[63:32];
                        r_armed <= 1'b1;
                    end
                    OP_RESUME: begin
                        r_armed <= 1'b1;
                        if (r_count != 4'd15) r_count <= r_count + 1'b1;
                    end
                    OP_TICK: if (r_armed && r_count > r_limit) begin
                        r_count <= '0;
                        r_armed <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_out_reached <= 1'b1;
                        r_out_lin <= '0;
                        r_out_ang <= '0;
                    end
                    default: ;
                endcase
            end
        end
        if (start) begin
            r_cx <= s_axis_tdata[31:0];
            r_cy <= s_axis_tdata[63:32];
            r_hd <= s_axis_tdata[79:64];
        end
        if (r_from_dp) begin
            r_out_lin <= dp_lin;
            r_out_ang <= dp_ang;
        end
    end

    gtg_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_status(status),
        .i_arrived(arrived), .o_cmd(cmd), .o_busy(busy), .o_decide(decide)
    );

    gtg_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_goal_x(r_goal_x), .i_goal_y(r_goal_y),
        .i_coord_x(start ? s_axis_tdata[31:0] : r_cx),
        .i_coord_y(start ? s_axis_tdata[63:32] : r_cy),
        .i_heading(r_hd),
        .i_linear_gain(r_lin_gain), .i_angular_gain(r_ang_gain),
        .i_max_linear_speed(r_max_lin), .i_max_angular_speed(r_max_ang),
        .i_arrival_radius(r_radius), .i_heading_gate(r_gate),
        .o_arrived(arrived), .o_linear_cmd(dp_lin), .o_angular_cmd(dp_ang)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {1'b0, r_out_ang, r_out_lin};
    assign m_axis_tuser = r_out_reached;

    `include "go_to_goal_heading_controller_core_assert.svh"
    `GTG_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, busy, !s_axis_tready)
    `GTG_ASSERT_NEXT(a_decide_disarms, i_clk, i_rst_n, decide, !r_armed && r_out_valid)
    `GTG_ASSERT_IMPL(a_stop_zero, i_clk, i_rst_n, r_out_valid && r_out_reached,
        r_out_lin == 0 && r_out_ang == 0)
endmodule
`default_nettype wire
